@@ rtl/core/ptst_pkg.sv @@
`timescale 1ns / 1ps
// Package: field widths, command and status codes, and sequencer states for the timer table.
package ptst_pkg;

    localparam int TIME_W   = 32;
    localparam int CMD_W    = 2;
    localparam int SEL_W    = 6;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 8;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 16;
    localparam int ENTRY_W  = 2 * TIME_W;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_PUSH
    } seq_state_t;

endpackage

@@ rtl/core/ptst_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ptst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/periodic_timer_slot_table_core.sv @@
`timescale 1ns / 1ps
// Periodic timer slot table: start / stop / tick over SLOTS slots, period and expiry in RAM.
// Sequence: start, stop and rejected words pass EXEC and PUSH on the way to the output register;
//   a tick also walks the slot RAM in WALK, one entry per cycle, before PUSH.
// Throughput: one word in flight; the next word is taken once the result reaches the
//   output register, even while that register still waits for m_tready.
// Reset (rst_n, async, active low): all slots inactive, timers disabled, no RAM clearing pass.
module periodic_timer_slot_table_core
    import ptst_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [31:0] interval, [37:32] slot_select, [69:38] now_ms
    input  logic [CMD_W-1:0]  s_tuser,   // [1:0] command
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [1:0] status, [7:2] slot_given, [15:8] fired_mask
    // configuration: timers_enabled
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // latched input word
    logic [CMD_W-1:0]  cmd_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [TIME_W-1:0] now_reg;

    logic              enabled_reg;
    logic [SLOTS-1:0]  active_reg;
    logic [SLOTS-1:0]  active_next;

    seq_state_t        state_reg;
    seq_state_t        state_next;

    // result being assembled
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [SEL_W-1:0]    given_reg;
    logic [SEL_W-1:0]    given_next;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-1:0]   mask_next;

    // output register
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    // tick walk: read issue counter and compare stage
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  issue_cnt_next;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;

    // RAM ports
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic [TIME_W-1:0]  rd_period;
    logic [TIME_W-1:0]  rd_expiry;
    logic               fire;

    // lowest free slot
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;

    logic               sel_ok;
    logic               out_free;
    logic               in_accept;
    logic               walk_done;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // one entry per slot: {period, expiry}
    ptst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_period = ram_rd_data[ENTRY_W-1:TIME_W];
    assign rd_expiry = ram_rd_data[TIME_W-1:0];
    // plain unsigned compare, no wrap handling
    assign fire      = cmp_vld_reg && active_reg[cmp_idx_reg] && (now_reg >= rd_expiry);
    assign walk_done = (issue_cnt_reg == CNT_W'(SLOTS)) && !cmp_vld_reg;

    // priority encoder, lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign sel_ok = (sel_reg < SEL_W'(SLOTS)) && active_reg[sel_reg[IDX_W-1:0]];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (enabled_reg && cmd_reg == CMD_TICK)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        s_tready       = 1'b0;
        status_next    = status_reg;
        given_next     = given_reg;
        mask_next      = mask_reg;
        active_next    = active_reg;
        issue_cnt_next = issue_cnt_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = cmp_idx_reg;
        ram_wr_data    = {rd_period, now_reg + rd_period};
        ram_rd_en      = 1'b0;
        ram_rd_addr    = issue_cnt_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                status_next    = STAT_REJECT;
                given_next     = '0;
                mask_next      = '0;
                issue_cnt_next = '0;
                if (enabled_reg)
                begin
                    case (cmd_reg)
                        CMD_START:
                        begin
                            if (interval_reg == '0)
                            begin
                                status_next = STAT_REJECT;
                            end
                            else if (!free_found)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                status_next           = STAT_OK;
                                given_next            = SEL_W'(free_idx);
                                active_next[free_idx] = 1'b1;
                                ram_wr_en             = 1'b1;
                                ram_wr_addr           = free_idx;
                                ram_wr_data           = {interval_reg, now_reg + interval_reg};
                            end
                        end
                        CMD_STOP:
                        begin
                            if (sel_ok)
                            begin
                                status_next                     = STAT_OK;
                                active_next[sel_reg[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        CMD_TICK:
                        begin
                            status_next = STAT_OK;
                        end
                        default:
                        begin
                            status_next = STAT_REJECT;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // read slot n while slot n-1 is compared and written back
                if (issue_cnt_reg != CNT_W'(SLOTS))
                begin
                    ram_rd_en      = 1'b1;
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (fire)
                begin
                    ram_wr_en = 1'b1;
                    mask_next = mask_reg | (MASK_W'(1) << cmp_idx_reg);
                end
            end
            ST_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enabled_reg   <= 1'b0;
            active_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            issue_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_vld_reg   <= ram_rd_en;
            if (cfg_valid && cfg_ready)
            begin
                enabled_reg <= cfg_data;
            end
            if (state_reg == ST_PUSH && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= s_tuser;
            interval_reg <= s_tdata[TIME_W-1:0];
            sel_reg      <= s_tdata[TIME_W+SEL_W-1:TIME_W];
            now_reg      <= s_tdata[2*TIME_W+SEL_W-1:TIME_W+SEL_W];
        end
        status_reg  <= status_next;
        given_reg   <= given_next;
        mask_reg    <= mask_next;
        cmp_idx_reg <= ram_rd_addr;
        if (state_reg == ST_PUSH && out_free)
        begin
            m_tdata_reg <= {mask_reg, given_reg, status_reg};
        end
    end

endmodule
